// File: sv/assert_macros.svh
// Assertion macros shared by the LRU replacement files.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_ALWAYS(label, expr, msg)
`endif
`endif

// File: sv/lru_pkg.sv
// Package for the LRU page replacement block: sizes and shared types.
// No dependencies.
package lru_pkg;
  localparam int FRAMES = 8;
  localparam int PAGES = 256;
  localparam int PAGE_W = 8;
  localparam int CNT_W = 4;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // result of one reference, handed from the core to the output stage
  typedef struct packed {
    logic  hit;
    logic  evicted;
    page_t evicted_page;
    cnt_t  frames_used;
  } lru_res_t;
endpackage

// File: sv/lru_core.sv
// Recency list held in a memory with a registered read, read-modify-write.
// Depends on lru_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lru_core
  import lru_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  page_t    page,
  input  cnt_t     limit,
  output logic     busy,
  output logic     done,
  output lru_res_t res
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  page_t  mem [FRAMES];
  page_t  rd_data;
  logic [IDX_W:0] rd_idx;   // next entry to read
  logic [IDX_W:0] wr_idx;   // entry being written
  logic [IDX_W:0] count;
  logic   found;
  page_t  carry;            // value moving one place down the list
  page_t  cur_page;
  cnt_t   cur_limit;
  logic   evicted;
  page_t  ev_page;

  // memory: one write, one registered read
  logic   mem_we;
  page_t  mem_wd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx[IDX_W-1:0]] <= mem_wd;
    rd_data <= mem[rd_idx[IDX_W-1:0]];
  end

  // walk: read entry i, write carry into i, carry becomes old entry
  logic last_entry;
  assign last_entry = (wr_idx + 1'b1 == count);
  always_comb begin
    mem_we = 1'b0;
    mem_wd = carry;
    if (state == S_WRITE) mem_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          cur_page <= page;
          cur_limit <= limit;
          carry <= page;
          found <= 1'b0;
          evicted <= 1'b0;
          ev_page <= '0;
          rd_idx <= '0;
          wr_idx <= '0;
          if (count == 0) state <= S_WRITE;
          else state <= S_READ;
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          // rd_data holds old entry wr_idx (or stale when beyond list)
          if (wr_idx >= count) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else if (rd_data == cur_page) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (last_entry && ({1'b0, count} >= {1'b0, cur_limit})) begin
            evicted <= 1'b1;
            ev_page <= rd_data;
            state <= S_DONE;
          end else begin
            carry <= rd_data;
            wr_idx <= wr_idx + 1'b1;
            rd_idx <= wr_idx + 1'b1;
            if (wr_idx + 1'b1 >= count) state <= S_WRITE;
            else state <= S_READ;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign res.hit = found;
  assign res.evicted = evicted;
  assign res.evicted_page = ev_page;
  assign res.frames_used = count[CNT_W-1:0];

  `ASSERT_ALWAYS(a_count_max, count <= FRAMES, "count above frames")
  `ASSERT_IMPL(a_one_flag, done |-> !(found && evicted), "hit and eviction together")
  `ASSERT_IMPL(a_start_idle, start && !busy |=> busy, "start not taken")
endmodule

// File: sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: handshakes, limit register.
// Depends on lru_pkg, lru_core and assert_macros.svh.
//
//  channel   signals                                        direction
//  input     in_valid in_ready page_number                  in
//  result    out_valid out_ready hit evicted evicted_page   out
//            frames_used
//  config    cfg_we cfg_data (frames_in_use)                in
//
// An item walks the list one entry at a time, a read then a write per entry,
// and one more write when a miss appends to a list with room; no new item
// is accepted until the core has finished the current one.
// A hit stops the walk at the match; a miss on a full list at the last entry.
// Reset empties the list and sets the limit to FRAMES; no clearing pass.
// A result waits in the output register; no item enters until it is taken.
`include "assert_macros.svh"
module lru_page_replacement
  import lru_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  page_t page_number,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  hit,
  output logic  evicted,
  output page_t evicted_page,
  output cnt_t  frames_used,
  input  logic  cfg_we,
  input  cnt_t  cfg_data
);
  cnt_t frames_in_use;
  cnt_t limit;
  logic busy, done;
  lru_res_t res;
  lru_res_t out_r;

  always_ff @(posedge clk) begin
    if (rst) frames_in_use <= cnt_t'(FRAMES);
    else if (cfg_we) frames_in_use <= cfg_data;
  end

  // clamp limit to 1..FRAMES
  always_comb begin
    limit = frames_in_use;
    if (limit == '0) limit = cnt_t'(1);
    if ({1'b0, limit} > (CNT_W+1)'(FRAMES)) limit = cnt_t'(FRAMES);
  end

  // accept only when a finishing result has room
  assign in_ready = !busy && !(out_valid && !out_ready);

  lru_core u_core (
    .clk(clk), .rst(rst), .start(in_valid && in_ready), .page(page_number),
    .limit(limit), .busy(busy), .done(done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (done) out_r <= res;
  end

  assign hit = out_r.hit;
  assign evicted = out_r.evicted;
  assign evicted_page = out_r.evicted_page;
  assign frames_used = out_r.frames_used;

  `ASSERT_IMPL(a_no_overrun, done |-> !out_valid || $past(out_ready), "result overrun")
  `ASSERT_IMPL(a_ev_zero, out_valid && !evicted |-> evicted_page == '0, "stray page")
  `ASSERT_IMPL(a_used_nz, out_valid |-> frames_used != '0, "empty after item")
endmodule
